>>> rtl/core/clv_pkg.sv
// Shared types and constants of the circular list engine.
package clv_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KIND_W   = 3;
	localparam int STAT_W   = 2;
	localparam int IN_DW    = 2 * DATA_W;
	localparam int OUT_DW   = ((CNT_W + DATA_W + 7) / 8) * 8;

	typedef enum logic [KIND_W-1:0] {
		K_INS_FRONT = 3'd0,
		K_INS_AFTER = 3'd1,
		K_INS_END   = 3'd2,
		K_DEL_FRONT = 3'd3,
		K_DEL_KEY   = 3'd4,
		K_DEL_END   = 3'd5,
		K_SEARCH    = 3'd6
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INS_FRONT,
		OP_INS_AFTER,
		OP_INS_END,
		OP_DEL_FRONT,
		OP_DEL_KEY,
		OP_DEL_END
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] new_value;
	} clv_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              vld;
		logic              mark;
		logic              first;
		logic [DATA_W-1:0] cv;
		logic              tok;
	} clv_link_t;

endpackage

>>> rtl/core/circular_list_engine.sv
// Top level of the circular list engine: control, status and the row of list cells.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | tuser: kind; tdata: key, new_value
//  m_*     | out | m_tvalid/m_tready  | tuser: status; tdata: entry_count, total
//
// Insert front, insert end, delete front, the unused kind and any word on an empty
// list go from accept straight to the apply state. Insert after, delete by value,
// delete end and search on a non-empty list first pass through the scan state: a scan
// token walks the cell row one cell a cycle. Reset clears the list at once. A new word
// is taken only when the previous one is done; a stalled result waits in the output
// register, and the apply state holds until that register is free.
module circular_list_engine import clv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,   // [31:0] key, [63:32] new_value
	input  logic [KIND_W-1:0] s_tuser,   // [2:0] kind
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,   // [6:0] entry_count, [38:7] total, rest zero
	output logic [STAT_W-1:0] m_tuser    // [1:0] status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY
	} state_t;

	state_t             state_q;
	logic               m_tvalid_q;
	logic [OUT_DW-1:0]  m_tdata_q;
	logic [STAT_W-1:0]  m_tuser_q;
	logic [CNT_W-1:0]   count_q;
	logic [DATA_W-1:0]  sum_q;
	logic               start_q;
	logic [KIND_W-1:0]  kind_q;
	logic [DATA_W-1:0]  key_q;
	logic [DATA_W-1:0]  new_q;

	clv_link_t          lk [CAPACITY+1];
	clv_link_t          tail_lk;
	clv_cmd_t           cmd;

	logic               accept;
	logic               go;
	logic               full;
	logic               empty;
	logic               found;
	logic               scan_kind;
	op_t                op_n;
	status_t            status_n;
	logic [CNT_W-1:0]   count_n;
	logic [DATA_W-1:0]  sum_n;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign go       = (state_q == S_APPLY) && (!m_tvalid_q || m_tready);

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign found = lk[CAPACITY].mark;

	assign scan_kind = (s_tuser == K_INS_AFTER) || (s_tuser == K_DEL_KEY) ||
		(s_tuser == K_DEL_END) || (s_tuser == K_SEARCH);

	assign lk[0].val   = new_q;
	assign lk[0].vld   = 1'b1;
	assign lk[0].mark  = 1'b0;
	assign lk[0].first = 1'b0;
	assign lk[0].cv    = '0;
	assign lk[0].tok   = start_q;
	assign tail_lk     = '0;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi < CAPACITY - 1) begin : g_mid
				clv_cell u_cell (
					.clk   (clk),
					.arst_n(arst_n),
					.cmd   (cmd),
					.left  (lk[gi]),
					.right (lk[gi+2]),
					.link  (lk[gi+1])
				);
			end else begin : g_last
				clv_cell u_cell (
					.clk   (clk),
					.arst_n(arst_n),
					.cmd   (cmd),
					.left  (lk[gi]),
					.right (tail_lk),
					.link  (lk[gi+1])
				);
			end
		end
	endgenerate

	always_comb begin
		op_n     = OP_HOLD;
		status_n = ST_OK;
		count_n  = count_q;
		sum_n    = sum_q;
		case (kind_q)
			K_INS_FRONT, K_INS_END: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					op_n    = (kind_q == K_INS_FRONT) ? OP_INS_FRONT : OP_INS_END;
					count_n = count_q + CNT_W'(1);
					sum_n   = sum_q + new_q;
				end
			end
			K_INS_AFTER: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else if (!found) begin
					status_n = ST_NOTFOUND;
				end else if (full) begin
					status_n = ST_FULL;
				end else begin
					op_n    = OP_INS_AFTER;
					count_n = count_q + CNT_W'(1);
					sum_n   = sum_q + new_q;
				end
			end
			K_DEL_FRONT: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					op_n    = OP_DEL_FRONT;
					count_n = count_q - CNT_W'(1);
					sum_n   = sum_q - lk[1].val;
				end
			end
			K_DEL_KEY: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else if (!found) begin
					status_n = ST_NOTFOUND;
				end else begin
					op_n    = OP_DEL_KEY;
					count_n = count_q - CNT_W'(1);
					sum_n   = sum_q - key_q;
				end
			end
			K_DEL_END: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					op_n    = OP_DEL_END;
					count_n = count_q - CNT_W'(1);
					sum_n   = sum_q - lk[CAPACITY].cv;
				end
			end
			K_SEARCH: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else if (!found) begin
					status_n = ST_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.op        = go ? op_n : OP_HOLD;
	assign cmd.key       = key_q;
	assign cmd.new_value = new_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			start_q    <= 1'b0;
		end else begin
			start_q <= accept && scan_kind && !empty;
			if (m_tvalid_q && m_tready && !go) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (scan_kind && !empty) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_APPLY;
						end
					end
				end
				S_SCAN: begin
					if (lk[CAPACITY].tok) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (go) begin
						count_q    <= count_n;
						sum_q      <= sum_n;
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= status_n;
						m_tdata_q  <= OUT_DW'({sum_n, count_n});
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			key_q  <= s_tdata[DATA_W-1:0];
			new_q  <= s_tdata[IN_DW-1:DATA_W];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> rtl/core/clv_cell.sv
// One list position: value, valid flag, scan flags and neighbor shifting.
module clv_cell import clv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  clv_cmd_t  cmd,
	input  clv_link_t left,
	input  clv_link_t right,
	output clv_link_t link
);

	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] cv_q;
	logic              vld_q;
	logic              mark_q;
	logic              first_q;
	logic              tok_q;

	logic [DATA_W-1:0] val_d;
	logic              vld_d;
	logic              hit;

	assign hit = vld_q && (val_q == cmd.key);

	always_comb begin
		val_d = val_q;
		vld_d = vld_q;
		case (cmd.op)
			OP_INS_FRONT: begin
				val_d = left.val;
				vld_d = left.vld;
			end
			OP_INS_AFTER: begin
				if (left.first) begin
					val_d = cmd.new_value;
					vld_d = 1'b1;
				end else if (left.mark) begin
					val_d = left.val;
					vld_d = left.vld;
				end
			end
			OP_INS_END: begin
				if (!vld_q && left.vld) begin
					val_d = cmd.new_value;
					vld_d = 1'b1;
				end
			end
			OP_DEL_FRONT: begin
				val_d = right.val;
				vld_d = right.vld;
			end
			OP_DEL_KEY: begin
				if (mark_q) begin
					val_d = right.val;
					vld_d = right.vld;
				end
			end
			OP_DEL_END: begin
				if (vld_q && !right.vld) begin
					vld_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			mark_q  <= 1'b0;
			first_q <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			vld_q <= vld_d;
			tok_q <= left.tok;
			if (left.tok) begin
				mark_q  <= left.mark | hit;
				first_q <= hit & ~left.mark;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		if (left.tok) begin
			cv_q <= vld_q ? val_q : left.cv;
		end
	end

	assign link.val   = val_q;
	assign link.vld   = vld_q;
	assign link.mark  = mark_q;
	assign link.first = first_q;
	assign link.cv    = cv_q;
	assign link.tok   = tok_q;

endmodule

>>> rtl/core/clv_checker.sv
// Port-level assertions for the circular list engine, bound to the top level.
module clv_checker import clv_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [IN_DW-1:0]  s_tdata,
	input logic [KIND_W-1:0] s_tuser,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_DW-1:0] m_tdata,
	input logic [STAT_W-1:0] m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while busy");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[CNT_W-1:0] == CNT_W'(CAPACITY)))
		else $error("full status with a free slot");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[CNT_W-1:0] == '0))
		else $error("empty status with live nodes");

	a_notfound_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_NOTFOUND) |-> (m_tdata[CNT_W-1:0] != '0))
		else $error("not found status on an empty list");

endmodule

bind circular_list_engine clv_checker u_clv_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for the circular list engine: random and directed list operations.
module tb_top;
	import clv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_WORDS = 650;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} list_cmd_t;

	typedef struct {
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] total;
	} list_result_t;

	typedef enum {GROW, SHRINK, CHURN} drift_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_DW-1:0]  s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_DW-1:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;

	list_cmd_t         pending_cmds[$];
	list_result_t      expected_results[$];
	logic [DATA_W-1:0] list_vals[$];

	int words_offered = 0;
	int words_taken = 0;
	int results_seen = 0;
	int mismatches = 0;
	int peak_size = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	int idle_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	circular_list_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic list_result_t advance_list(logic [KIND_W-1:0] kind,
			logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
		list_result_t r;
		int hit;
		logic [DATA_W-1:0] sum;
		r.status = ST_OK;
		hit = -1;
		foreach (list_vals[i]) begin
			if (hit < 0 && list_vals[i] == key) hit = i;
		end
		case (kind)
			K_INS_FRONT, K_INS_END: begin
				if (list_vals.size() == CAPACITY) r.status = ST_FULL;
				else if (kind == K_INS_FRONT) list_vals.push_front(value);
				else list_vals.push_back(value);
			end
			K_INS_AFTER: begin
				if (list_vals.size() == 0) r.status = ST_EMPTY;
				else if (hit < 0) r.status = ST_NOTFOUND;
				else if (list_vals.size() == CAPACITY) r.status = ST_FULL;
				else list_vals.insert(hit + 1, value);
			end
			K_DEL_FRONT: begin
				if (list_vals.size() == 0) r.status = ST_EMPTY;
				else void'(list_vals.pop_front());
			end
			K_DEL_KEY: begin
				if (list_vals.size() == 0) r.status = ST_EMPTY;
				else if (hit < 0) r.status = ST_NOTFOUND;
				else list_vals.delete(hit);
			end
			K_DEL_END: begin
				if (list_vals.size() == 0) r.status = ST_EMPTY;
				else void'(list_vals.pop_back());
			end
			K_SEARCH: begin
				if (list_vals.size() == 0) r.status = ST_EMPTY;
				else if (hit < 0) r.status = ST_NOTFOUND;
			end
			default: ;
		endcase
		sum = '0;
		foreach (list_vals[i]) sum += list_vals[i];
		r.count = CNT_W'(list_vals.size());
		r.total = sum;
		if (list_vals.size() > peak_size) peak_size = list_vals.size();
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] draw_operand();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return DATA_W'($signed($urandom_range(0, 11)) - 6);
		if (r < 60) begin
			case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [KIND_W-1:0] draw_kind(drift_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			GROW: begin
				if (r < 80) return KIND_W'($urandom_range(0, 2));
				return KIND_W'($urandom_range(3, 6));
			end
			SHRINK: begin
				if (r < 75) return KIND_W'($urandom_range(3, 5));
				r = $urandom_range(0, 3);
				return (r == 3) ? K_SEARCH : KIND_W'(r);
			end
			default: begin
				if (r < 2) return KIND_UNUSED;
				return KIND_W'($urandom_range(0, 6));
			end
		endcase
	endfunction

	task automatic push_cmd(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] key,
			logic [DATA_W-1:0] value);
		list_cmd_t c;
		c.kind = kind;
		c.key = key;
		c.value = value;
		pending_cmds.push_back(c);
	endtask

	task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
		$display("error: result %0d field %s expected 0x%0h got 0x%0h",
			results_seen, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_cmds.size() > 0 &&
					((words_offered >= 250 && words_offered < 400) ||
					$urandom_range(0, 99) >= 14)) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_cmds[0].kind;
				s_tdata <= {pending_cmds[0].value, pending_cmds[0].key};
				void'(pending_cmds.pop_front());
				words_offered++;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && results_seen >= 100) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= (results_seen >= 250 && results_seen < 400) ||
				$urandom_range(0, 99) >= 14;
		end
	end

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected word", 0, m_tdata);
				end else begin
					want = expected_results.pop_front();
					status_seen[want.status]++;
					if (m_tuser !== want.status)
						report_mismatch("status", want.status, m_tuser);
					if (m_tdata[CNT_W-1:0] !== want.count)
						report_mismatch("entry_count", want.count, m_tdata[CNT_W-1:0]);
					if (m_tdata[CNT_W+DATA_W-1:CNT_W] !== want.total)
						report_mismatch("total", want.total, m_tdata[CNT_W+DATA_W-1:CNT_W]);
					if (m_tdata[OUT_DW-1:CNT_W+DATA_W] !== '0)
						report_mismatch("pad", 0, m_tdata[OUT_DW-1:CNT_W+DATA_W]);
				end
				results_seen++;
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(advance_list(s_tuser, s_tdata[DATA_W-1:0],
					s_tdata[IN_DW-1:DATA_W]));
				words_taken++;
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		drift_t mode;
		int random_words;
		int len;
		push_cmd(K_DEL_FRONT, 32'd0, 32'd0);
		push_cmd(K_DEL_KEY, 32'd0, 32'd0);
		push_cmd(K_DEL_END, 32'd0, 32'd0);
		push_cmd(K_SEARCH, 32'd0, 32'd0);
		push_cmd(K_INS_AFTER, 32'd0, 32'd9);
		push_cmd(KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
		push_cmd(K_INS_FRONT, 32'd0, 32'h7fff_ffff);
		push_cmd(K_INS_END, 32'd0, 32'h8000_0000);
		push_cmd(K_INS_FRONT, 32'd0, 32'hffff_ffff);
		push_cmd(K_INS_AFTER, 32'h7fff_ffff, 32'd0);
		push_cmd(K_INS_AFTER, 32'h8000_0000, 32'd5);
		push_cmd(K_INS_AFTER, 32'd12345, 32'd1);
		push_cmd(K_SEARCH, 32'd0, 32'd0);
		push_cmd(K_SEARCH, 32'd99, 32'd0);
		push_cmd(K_INS_END, 32'd0, 32'd5);
		push_cmd(K_DEL_KEY, 32'd5, 32'd0);
		push_cmd(K_DEL_KEY, 32'd77, 32'd0);
		push_cmd(K_DEL_KEY, 32'hffff_ffff, 32'd0);
		push_cmd(K_DEL_KEY, 32'd5, 32'd0);
		push_cmd(K_DEL_END, 32'd0, 32'd0);
		push_cmd(K_DEL_FRONT, 32'd0, 32'd0);
		push_cmd(K_DEL_END, 32'd0, 32'd0);
		push_cmd(K_INS_END, 32'd0, 32'd1);
		push_cmd(K_DEL_KEY, 32'd1, 32'd0);
		random_words = 0;
		repeat (72) begin
			push_cmd($urandom_range(0, 1) ? K_INS_END : K_INS_FRONT, draw_operand(),
				draw_operand());
			random_words++;
		end
		while (random_words < RANDOM_WORDS) begin
			mode = drift_t'($urandom_range(0, 2));
			len = $urandom_range(20, 80);
			if (len > RANDOM_WORDS - random_words) len = RANDOM_WORDS - random_words;
			repeat (len) begin
				push_cmd(draw_kind(mode), draw_operand(), draw_operand());
				random_words++;
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (CAPACITY + 10) @(posedge clk);

		$display("covered %0d words and %0d results; list size peaked at %0d of %0d",
			words_taken, results_seen, peak_size, CAPACITY);
		$display("statuses: ok %0d, empty %0d, not found %0d, full %0d",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOTFOUND],
			status_seen[ST_FULL]);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
